[rtl/core/crcfr_pkg.sv]
// Package for the CRC-16 frame receiver with frame queue.
// Holds request/result payload types, command and event codes, defaults and the CRC step.
// Depends on nothing; every module of the block uses it.
package crcfr_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned BODY_MAX_DEF    = 256;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Configuration registers and their reset values.
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BYTE   = 1'b1;
  localparam logic [7:0] START_BYTE_RST = 8'hAA;
  localparam logic [7:0] END_BYTE_RST   = 8'h55;

  // CRC-16/CCITT, no reflection, no final xor.
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;
  localparam int unsigned MIN_BODY = 3;

  // Command codes of a request.
  typedef enum logic [1:0] {
    CMD_FEED    = 2'd0,
    CMD_READ    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  // Event codes reported with each result.
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_QUEUED  = 3'd1,
    EV_BAD_LEN = 3'd2,
    EV_BAD_CRC = 3'd3,
    EV_BAD_END = 3'd4,
    EV_FULL    = 3'd5
  } event_e;

  // Request payload as it arrives on the input channel.
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic [7:0] read_index;
  } req_t;

  // Result payload as it leaves on the output channel.
  typedef struct packed {
    logic [2:0] frame_event;
    logic [1:0] frames_waiting;
    logic [8:0] head_length;
    logic [7:0] read_byte;
    logic       read_valid;
  } rsp_t;

  // Classified request held in the queue between front and back.
  typedef struct packed {
    logic       is_feed;
    logic       is_read;
    logic       is_release;
    logic [7:0] data_byte;
    logic [7:0] read_index;
  } item_t;

  // Front-to-back queue status.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // One byte of the CRC update, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/crcfr_front.sv]
// Front end of the frame receiver: takes requests, decodes the command and
// buffers the classified request in a two-entry queue. Depends on crcfr_pkg.
module crcfr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  crcfr_pkg::req_t       in_data_i,
  output logic                  in_stall_o,
  output crcfr_pkg::queue_head_t head_o,
  input  logic                  pop_i
);

  localparam int unsigned DEPTH = 2;

  crcfr_pkg::item_t entry_q [DEPTH];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             push;
  logic             pop;
  crcfr_pkg::item_t item_in;

  // Decode the command into one-hot operation flags; code 3 does nothing.
  always_comb begin
    item_in            = '0;
    item_in.data_byte  = in_data_i.data_byte;
    item_in.read_index = in_data_i.read_index;
    unique case (crcfr_pkg::cmd_e'(in_data_i.cmd))
      crcfr_pkg::CMD_FEED:    item_in.is_feed    = 1'b1;
      crcfr_pkg::CMD_READ:    item_in.is_read    = 1'b1;
      crcfr_pkg::CMD_RELEASE: item_in.is_release = 1'b1;
      default:                item_in.is_feed    = 1'b0;
    endcase
  end

  // Queue control.
  assign in_stall_o = (count_q == 2'(DEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= item_in;
    end
  end

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = entry_q[rd_ptr_q];

endmodule

[rtl/core/crcfr_back.sv]
// Back end of the frame receiver: frame parser with CRC check, frame store ring,
// host read/release and the output register. Depends on crcfr_pkg.
module crcfr_back #(
  parameter int unsigned BODY_MAX    = crcfr_pkg::BODY_MAX_DEF,
  parameter int unsigned QUEUE_DEPTH = crcfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [crcfr_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [crcfr_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  crcfr_pkg::queue_head_t              head_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  output crcfr_pkg::rsp_t                     out_data_o,
  input  logic                                out_stall_i
);

  localparam int unsigned SLOT_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned PTR_W     = SLOT_W + 1;
  localparam int unsigned OFS_W     = $clog2(BODY_MAX);
  localparam int unsigned CNT_W     = $clog2(BODY_MAX + 1);
  localparam int unsigned ADDR_W    = SLOT_W + OFS_W;
  localparam int unsigned MEM_DEPTH = QUEUE_DEPTH << OFS_W;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_LEN_LO = 3'd2,
    PH_BODY   = 3'd3,
    PH_CRC_HI = 3'd4,
    PH_CRC_LO = 3'd5,
    PH_END    = 3'd6
  } phase_e;

  // Receive state, queue pointers and configuration.
  phase_e            phase_q, phase_d;
  logic [7:0]        len_hi_q, len_hi_d;
  logic [CNT_W-1:0]  body_len_q, body_len_d;
  logic [CNT_W-1:0]  body_cnt_q, body_cnt_d;
  logic [15:0]       crc_q, crc_d;
  logic [SLOT_W-1:0] rd_slot_q, rd_slot_d;
  logic [SLOT_W-1:0] wr_slot_q, wr_slot_d;
  logic [7:0]        start_byte_q;
  logic [7:0]        end_byte_q;

  // Output register; the read byte sits in mem_rdata_q alongside it.
  logic                  out_valid_q;
  logic [2:0]            out_event_q;
  logic [1:0]            out_wait_q;
  logic [8:0]            out_hlen_q;
  logic                  out_rvalid_q;

  // Storage.
  logic [7:0]            mem_q [MEM_DEPTH];
  logic [7:0]            mem_rdata_q;
  logic [CNT_W-1:0]      slot_len_q [QUEUE_DEPTH];

  logic                  exec;
  logic [7:0]            b;
  logic [15:0]           len16;
  logic [CNT_W-1:0]      cnt_inc;
  crcfr_pkg::event_e     ev;
  logic                  mem_we;
  logic                  mem_re;
  logic                  len_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [ADDR_W-1:0]     mem_raddr;
  logic                  nonempty_q;
  logic                  nonempty_d;
  logic [CNT_W-1:0]      hlen;
  logic [16:0]           idx_w;
  logic                  rvalid;
  logic [PTR_W-1:0]      wr_ext;
  logic [PTR_W-1:0]      rd_ext;
  logic [PTR_W-1:0]      waiting;

  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
    logic [PTR_W-1:0] n;
    n = {1'b0, s} + PTR_W'(1);
    return (n >= PTR_W'(QUEUE_DEPTH)) ? '0 : n[SLOT_W-1:0];
  endfunction

  // An item runs when one is queued and the output register is free or draining.
  assign exec  = head_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o = exec;
  assign b     = head_i.item.data_byte;
  assign len16 = {len_hi_q, b};
  assign cnt_inc = body_cnt_q + CNT_W'(1);

  // Frame parser for feed requests.
  always_comb begin
    phase_d    = phase_q;
    len_hi_d   = len_hi_q;
    body_len_d = body_len_q;
    body_cnt_d = body_cnt_q;
    crc_d      = crc_q;
    wr_slot_d  = wr_slot_q;
    ev         = crcfr_pkg::EV_NONE;
    mem_we     = 1'b0;
    len_we     = 1'b0;
    if (exec && head_i.item.is_feed) begin
      unique case (phase_q)
        PH_START: begin
          if (b == start_byte_q) phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_hi_d = b;
          phase_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if ((len16 < 16'(crcfr_pkg::MIN_BODY)) || (17'(len16) > 17'(BODY_MAX))) begin
            ev      = crcfr_pkg::EV_BAD_LEN;
            phase_d = PH_START;
          end else begin
            body_len_d = CNT_W'(len16);
            body_cnt_d = '0;
            crc_d      = crcfr_pkg::CRC_INIT;
            phase_d    = PH_BODY;
          end
        end
        PH_BODY: begin
          mem_we     = 1'b1;
          crc_d      = crcfr_pkg::crc16_byte(crc_q, b);
          body_cnt_d = cnt_inc;
          if (cnt_inc >= body_len_q) phase_d = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          if (b != crc_q[15:8]) begin
            ev      = crcfr_pkg::EV_BAD_CRC;
            phase_d = PH_START;
          end else begin
            phase_d = PH_CRC_LO;
          end
        end
        PH_CRC_LO: begin
          if (b != crc_q[7:0]) begin
            ev      = crcfr_pkg::EV_BAD_CRC;
            phase_d = PH_START;
          end else begin
            phase_d = PH_END;
          end
        end
        PH_END: begin
          if (b != end_byte_q) begin
            ev = crcfr_pkg::EV_BAD_END;
          end else if (slot_next(wr_slot_q) == rd_slot_q) begin
            ev = crcfr_pkg::EV_FULL;
          end else begin
            len_we    = 1'b1;
            wr_slot_d = slot_next(wr_slot_q);
            ev        = crcfr_pkg::EV_QUEUED;
          end
          phase_d = PH_START;
        end
        default: begin
          phase_d = PH_START;
        end
      endcase
    end
  end

  // Release of the oldest frame.
  assign nonempty_q = (rd_slot_q != wr_slot_q);
  assign rd_slot_d  = (exec && head_i.item.is_release && nonempty_q) ?
                      slot_next(rd_slot_q) : rd_slot_q;
  assign nonempty_d = (rd_slot_d != wr_slot_d);

  // Head length after this item; a frame just queued into an empty ring is bypassed.
  always_comb begin
    if (!nonempty_d) begin
      hlen = '0;
    end else if (len_we && (rd_slot_d == wr_slot_q)) begin
      hlen = body_len_q;
    end else begin
      hlen = slot_len_q[rd_slot_d];
    end
  end

  // Host byte read from the oldest frame.
  assign idx_w  = 17'(head_i.item.read_index);
  assign rvalid = head_i.item.is_read && nonempty_q && (idx_w < 17'(hlen)) &&
                  (idx_w < 17'(BODY_MAX));
  assign mem_re    = exec && rvalid;
  assign mem_raddr = {rd_slot_q, idx_w[OFS_W-1:0]};
  assign mem_waddr = {wr_slot_q, body_cnt_q[OFS_W-1:0]};

  // Frames waiting, modulo the ring size.
  assign wr_ext  = {1'b0, wr_slot_d};
  assign rd_ext  = {1'b0, rd_slot_d};
  assign waiting = (wr_ext >= rd_ext) ? (wr_ext - rd_ext) :
                   (wr_ext + PTR_W'(QUEUE_DEPTH) - rd_ext);

  // Control state, configuration and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_START;
      len_hi_q     <= '0;
      body_len_q   <= '0;
      body_cnt_q   <= '0;
      crc_q        <= '0;
      rd_slot_q    <= '0;
      wr_slot_q    <= '0;
      start_byte_q <= crcfr_pkg::START_BYTE_RST;
      end_byte_q   <= crcfr_pkg::END_BYTE_RST;
      out_valid_q  <= 1'b0;
      out_event_q  <= '0;
      out_wait_q   <= '0;
      out_hlen_q   <= '0;
      out_rvalid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      len_hi_q   <= len_hi_d;
      body_len_q <= body_len_d;
      body_cnt_q <= body_cnt_d;
      crc_q      <= crc_d;
      rd_slot_q  <= rd_slot_d;
      wr_slot_q  <= wr_slot_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          crcfr_pkg::CFG_START_BYTE: start_byte_q <= cfg_wdata_i;
          crcfr_pkg::CFG_END_BYTE:   end_byte_q   <= cfg_wdata_i;
          default:                   end_byte_q   <= end_byte_q;
        endcase
      end
      if (exec) begin
        out_valid_q  <= 1'b1;
        out_event_q  <= ev;
        out_wait_q   <= waiting[1:0];
        out_hlen_q   <= 9'(hlen);
        out_rvalid_q <= rvalid;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Frame store: body bytes go in as they arrive, host reads come out registered.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= b;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  // Body length of each queued slot.
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      slot_len_q[wr_slot_q] <= body_len_q;
    end
  end

  assign out_valid_o                = out_valid_q;
  assign out_data_o.frame_event     = out_event_q;
  assign out_data_o.frames_waiting  = out_wait_q;
  assign out_data_o.head_length     = out_hlen_q;
  assign out_data_o.read_byte       = out_rvalid_q ? mem_rdata_q : 8'h00;
  assign out_data_o.read_valid      = out_rvalid_q;

endmodule

[rtl/core/crc16_frame_receiver_queue_unit.sv]
// Top level of the CRC-16 frame receiver with frame queue.
// Instantiates crcfr_front and crcfr_back; depends on crcfr_pkg.
//
// The block takes one request per clock cycle when in_stall_o is low and
// gives one result for each request, in order. Feed requests push line
// bytes through a frame parser (start byte, 16-bit big-endian length, body,
// CRC-16/CCITT high then low, end byte); good frames land in a ring of
// QUEUE_DEPTH slots that holds up to QUEUE_DEPTH-1 frames, each slot sized
// for BODY_MAX bytes. Read and release requests act on the oldest frame. An
// accepted request is written into the two-entry input queue; from its head
// the execute stage works on it, and its result, with the registered frame
// store read data, then sits in the output register. Sustained throughput is
// one request per cycle while out_stall_i is low, set by the single execute
// stage that updates the CRC and the store for one byte per cycle.
// Configuration writes are taken at any time, but requests already queued
// see the new values, so writes belong in idle periods.
module crc16_frame_receiver_queue_unit #(
  parameter int unsigned BODY_MAX    = crcfr_pkg::BODY_MAX_DEF,
  parameter int unsigned QUEUE_DEPTH = crcfr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [crcfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [crcfr_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  input  crcfr_pkg::req_t                  in_data_i,
  output logic                             in_stall_o,
  output logic                             out_valid_o,
  output crcfr_pkg::rsp_t                  out_data_o,
  input  logic                             out_stall_i
);

  crcfr_pkg::queue_head_t head;
  logic                   pop;

  // Request decode and buffering.
  crcfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .head_o     (head),
    .pop_i      (pop)
  );

  // Frame parsing, frame store and result generation.
  crcfr_back #(
    .BODY_MAX    (BODY_MAX),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
